// ===== hdl/nhlt_pkg.sv =====
// Package for the next-hop learning table: payload structs, codes and sizes.
// No dependencies; every other file in hdl/ imports it.
package nhlt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic       OP_LEARN       = 1'b0;
   localparam logic       OP_LOOKUP      = 1'b1;
   localparam logic [7:0] DATA_TO_SERVER = 8'd2;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_FOUND    = 3'd4;
   localparam logic [2:0] ST_NO_ROUTE = 3'd5;

   localparam logic [1:0] KIND_IGNORE = 2'd0;
   localparam logic [1:0] KIND_LEARN  = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   typedef struct packed {
      logic       op;
      logic       frame_ok;
      logic [7:0] cast_kind;
      logic [7:0] msg_type;
      logic [7:0] sender_rank;
      logic [7:0] target_hi;
      logic [7:0] target_lo;
      logic [7:0] reading;
      logic [7:0] src_hi;
      logic [7:0] src_lo;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] next_hop_hi;
      logic [7:0] next_hop_lo;
      logic [7:0] out_rank;
      logic [7:0] out_value;
   } rsp_type;

   // Work handed from the front end to the table engine
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] target;
      logic [15:0] src;
      logic [7:0]  rank;
      logic [7:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [15:0] target;
      logic [15:0] hop;
   } entry_type;

endpackage

// ===== hdl/nhlt_front.sv =====
// Front end: takes request transfers, holds own_rank and the last message,
// classifies each item into a command. Depends on nhlt_pkg.
module nhlt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  nhlt_pkg::req_type req_data,
   input  logic             csr_write,
   input  logic [7:0]       csr_data,
   output nhlt_pkg::cmd_type cmd
);
   import nhlt_pkg::*;

   logic [7:0]  own_rank_ff,    own_rank_in;
   logic [15:0] last_target_ff, last_target_in;
   logic [7:0]  last_value_ff,  last_value_in;
   logic [15:0] target;
   logic        rank_ok;

   assign target  = {req_data.target_hi, req_data.target_lo};
   assign rank_ok = {1'b0, req_data.sender_rank} == ({1'b0, own_rank_ff} + 9'd1);

   always_comb begin
      own_rank_in    = csr_write ? csr_data : own_rank_ff;
      last_target_in = last_target_ff;
      last_value_in  = last_value_ff;
      cmd.kind       = KIND_IGNORE;
      cmd.target     = target;
      cmd.src        = {req_data.src_hi, req_data.src_lo};
      cmd.rank       = own_rank_ff;
      cmd.value      = last_value_ff;
      if (req_data.op == OP_LOOKUP) begin
         cmd.kind   = KIND_LOOKUP;
         cmd.target = last_target_ff;
      end else if (req_data.frame_ok) begin
         // latch any frame of good length
         if (accept) begin
            last_target_in = target;
            last_value_in  = req_data.reading;
         end
         if (req_data.cast_kind != 8'd0 && req_data.msg_type == DATA_TO_SERVER
             && rank_ok) begin
            cmd.kind = KIND_LEARN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_rank_ff    <= 8'd1;
         last_target_ff <= '0;
         last_value_ff  <= '0;
      end else begin
         own_rank_ff    <= own_rank_in;
         last_target_ff <= last_target_in;
         last_value_ff  <= last_value_in;
      end
   end

endmodule

// ===== hdl/nhlt_queue.sv =====
// Short command queue between front end and table engine.
// Depends on nhlt_pkg.
module nhlt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nhlt_pkg::cmd_type push_cmd,
   input  logic              pop,
   output nhlt_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import nhlt_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/nhlt_back.sv =====
// Table engine: holds the route memory and alive marks, scans one entry per
// clock per learn or lookup, issues the result strobe. Depends on nhlt_pkg.
module nhlt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  nhlt_pkg::cmd_type q_head,
   output logic              pop,
   output logic              rsp_valid,
   output nhlt_pkg::rsp_type rsp_data
);
   import nhlt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   entry_type mem [TABLE_DEPTH];

   logic [1:0]             state_ff,      state_in;
   cmd_type                cmd_ff,        cmd_in;
   logic [TABLE_DEPTH-1:0] alive_ff,      alive_in;
   logic [IDX_W-1:0]       scan_idx_ff,   scan_idx_in;
   logic                   issue_ff,      issue_in;
   logic                   cmp_valid_ff,  cmp_valid_in;
   logic [IDX_W-1:0]       cmp_idx_ff,    cmp_idx_in;
   logic                   cmp_alive_ff,  cmp_alive_in;
   entry_type              rd_data_ff;
   logic                   hit_ff,        hit_in;
   logic [IDX_W-1:0]       hit_idx_ff,    hit_idx_in;
   logic [15:0]            hit_hop_ff,    hit_hop_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff,   free_idx_in;
   logic                   rsp_valid_ff,  rsp_valid_in;
   rsp_type                rsp_data_ff,   rsp_data_in;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;
   logic                   match;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign match     = cmp_alive_ff && (rd_data_ff.target == cmd_ff.target);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      alive_in      = alive_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = scan_idx_ff;
      cmp_alive_in  = alive_ff[scan_idx_ff];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_hop_in    = hit_hop_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = hit_idx_ff;
      mem_wdata     = {cmd_ff.target, cmd_ff.src};

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_head;
               if (q_head.kind == KIND_IGNORE) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = ST_IGNORED;
                  rsp_data_in.next_hop_hi = '0;
                  rsp_data_in.next_hop_lo = '0;
                  rsp_data_in.out_rank    = '0;
                  rsp_data_in.out_value   = '0;
               end else begin
                  state_in      = S_SCAN;
                  scan_idx_in   = '0;
                  issue_in      = 1'b1;
                  hit_in        = 1'b0;
                  free_found_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            // issue side: one read per clock
            if (issue_ff) begin
               cmp_valid_in = 1'b1;
               if (scan_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
            // compare side: entry read in the previous clock
            if (cmp_valid_ff) begin
               if (!cmp_alive_ff && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  hit_hop_in = rd_data_ff.hop;
                  state_in   = S_DONE;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            state_in                = S_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_data_in.next_hop_hi = '0;
            rsp_data_in.next_hop_lo = '0;
            rsp_data_in.out_rank    = '0;
            rsp_data_in.out_value   = '0;
            if (cmd_ff.kind == KIND_LOOKUP) begin
               rsp_data_in.out_rank  = cmd_ff.rank;
               rsp_data_in.out_value = cmd_ff.value;
               if (hit_ff) begin
                  rsp_data_in.status      = ST_FOUND;
                  rsp_data_in.next_hop_hi = hit_hop_ff[15:8];
                  rsp_data_in.next_hop_lo = hit_hop_ff[7:0];
               end else begin
                  rsp_data_in.status = ST_NO_ROUTE;
               end
            end else if (hit_ff) begin
               mem_we             = 1'b1;
               mem_waddr          = hit_idx_ff;
               rsp_data_in.status = ST_UPDATED;
            end else if (free_found_ff) begin
               mem_we                = 1'b1;
               mem_waddr             = free_idx_ff;
               alive_in[free_idx_ff] = 1'b1;
               rsp_data_in.status    = ST_INSERTED;
            end else begin
               rsp_data_in.status = ST_FULL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Route memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmp_alive_ff  <= cmp_alive_in;
      hit_idx_ff    <= hit_idx_in;
      hit_hop_ff    <= hit_hop_in;
      free_idx_ff   <= free_idx_in;
      rsp_data_ff   <= rsp_data_in;
      hit_ff        <= hit_in;
      free_found_ff <= free_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alive_ff     <= '0;
         issue_ff     <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/next_hop_learning_table_top.sv =====
// Top level of the next-hop learning table: front end, command queue, engine.
// Depends on nhlt_pkg, nhlt_front, nhlt_queue and nhlt_back.
//
// A request transfer happens on a clock edge with req_start high and busy
// low. Each item gives exactly one result, shown on rsp_data for a single
// clock with rsp_valid high; the receiver cannot hold it off, so capture it
// on that edge. Items are classified on entry (the last message is latched
// there) and wait in a two-deep command queue; busy rises only when that
// queue is full. An ignored learn is answered from the engine's idle state
// without a scan. A learn that qualifies, or any lookup, scans the route
// table through its single read port at one entry per clock, ending early
// on a match. Alive marks are flip-flops cleared by reset, so there is no
// clearing pass and the block is ready in the clock after reset falls.
// own_rank is written through csr_valid/csr_data; csr_ready is always
// high, and writes are to be made only while no item is outstanding.
module next_hop_learning_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  nhlt_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output nhlt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import nhlt_pkg::*;

   logic    accept;
   logic    csr_write;
   cmd_type front_cmd;
   cmd_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   // hold off new requests only while the queue has no room
   assign busy      = q_full;
   assign accept    = req_start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // classify and latch the last message
   nhlt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd       (front_cmd)
   );

   // decouple front end from the table scan
   nhlt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // scan the table, update it and drive the result strobe
   nhlt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
